>>> src/mbps_pkg.sv
// Package for the masked byte pattern search unit: word types, register codes, defaults.
`timescale 1ns / 1ps
`default_nettype none
package mbps_pkg;

  localparam int unsigned          PATTERN_MAX_DEF  = 32;
  localparam longint unsigned      HAYSTACK_MAX_DEF = 64'd65536;

  localparam int unsigned          PAT_BYTES  = 32;            // bytes held by pattern regs
  localparam logic [15:0]          OFFSET_SAT = 16'hFFFF;

  localparam int unsigned          CFG_IDX_W  = 3;
  localparam int unsigned          CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_24_31 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [15:0] match_offset;
    logic        too_long;
  } out_word_t;

  // Register file contents handed to the scan datapath
  typedef struct packed {
    logic [8*PAT_BYTES-1:0] pattern;
    logic [PAT_BYTES-1:0]   care;
    logic [5:0]             length;
  } cfg_t;

endpackage
`default_nettype wire

>>> src/mbps_cfg_regs.sv
// Configuration registers: pattern bytes, care mask and pattern length.
`timescale 1ns / 1ps
`default_nettype none
module mbps_cfg_regs (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               wr_en,
  input  wire [mbps_pkg::CFG_IDX_W-1:0]     wr_index,
  input  wire [mbps_pkg::CFG_DATA_W-1:0]    wr_data,
  output mbps_pkg::cfg_t                    cfg
);
  import mbps_pkg::*;

  logic [63:0] pat0_r, pat1_r, pat2_r, pat3_r;
  logic [31:0] care_r;
  logic [5:0]  len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat0_r <= '0;
      pat1_r <= '0;
      pat2_r <= '0;
      pat3_r <= '0;
      care_r <= '1;
      len_r  <= 6'd1;
    end else if (wr_en) begin
      case (wr_index)
        CFG_PAT_0_7:   pat0_r <= wr_data;
        CFG_PAT_8_15:  pat1_r <= wr_data;
        CFG_PAT_16_23: pat2_r <= wr_data;
        CFG_PAT_24_31: pat3_r <= wr_data;
        CFG_CARE_MASK: care_r <= wr_data[31:0];
        CFG_PAT_LEN:   len_r  <= wr_data[5:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign cfg.pattern = {pat3_r, pat2_r, pat1_r, pat0_r};
  assign cfg.care    = care_r;
  assign cfg.length  = len_r;

endmodule
`default_nettype wire

>>> src/mbps_scan.sv
// Scan datapath: byte window, haystack counters and masked window compare.
`timescale 1ns / 1ps
`default_nettype none
module mbps_scan #(
  parameter int unsigned     PATTERN_MAX  = mbps_pkg::PATTERN_MAX_DEF,
  parameter longint unsigned HAYSTACK_MAX = mbps_pkg::HAYSTACK_MAX_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step,
  input  mbps_pkg::in_word_t   in_word,
  input  mbps_pkg::cfg_t       cfg,
  output logic                 res_valid,
  output mbps_pkg::out_word_t  res_word
);
  import mbps_pkg::*;

  // Only the newest min(PATTERN_MAX, 32) bytes can ever be compared
  localparam int unsigned W      = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
  localparam int unsigned IDX_W  = $clog2(W);
  localparam longint unsigned SAT_VAL = HAYSTACK_MAX + longint'(PATTERN_MAX);
  localparam int unsigned CNT_W  = $clog2(SAT_VAL + 1);
  localparam int unsigned OW     = (CNT_W > 16) ? CNT_W : 16;
  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(SAT_VAL);
  localparam logic [CNT_W-1:0] CNT_HMAX = CNT_W'(HAYSTACK_MAX);
  localparam logic [5:0]       LEN_CAP  = 6'(W);

  logic [7:0]       win_r [W-1];
  logic [7:0]       win_nxt [W];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             rep_r;
  logic [5:0]       len_eff;
  logic             match_ok, hit;
  logic [OW-1:0]    cnt_ext, len_ext, off;

  // Shifted window including the arriving byte; entry 0 is newest
  always_comb begin
    win_nxt[0] = in_word.data_byte;
    for (int k = 1; k < W; k++) win_nxt[k] = win_r[k-1];
  end

  always_comb begin
    if (cfg.length == 6'd0)      len_eff = 6'd1;
    else if (cfg.length > LEN_CAP) len_eff = LEN_CAP;
    else                         len_eff = cfg.length;
  end

  assign cnt_nxt = (cnt_r < CNT_SAT) ? cnt_r + CNT_W'(1) : cnt_r;
  assign ovf_nxt = ovf_r | (cnt_nxt > CNT_HMAX);

  // Pattern byte j lines up with window entry len-1-j
  always_comb begin
    logic [5:0] pos;
    match_ok = 1'b1;
    pos      = '0;
    for (int j = 0; j < W; j++) begin
      pos = len_eff - 6'(j) - 6'd1;
      if ((6'(j) < len_eff) && cfg.care[j] &&
          (win_nxt[pos[IDX_W-1:0]] != cfg.pattern[8*j +: 8]))
        match_ok = 1'b0;
    end
  end

  assign cnt_ext = OW'(cnt_nxt);
  assign len_ext = OW'(len_eff);
  assign hit     = !rep_r && (cnt_ext >= len_ext) && match_ok;
  assign off     = cnt_ext - len_ext;

  assign res_valid = !rep_r && (hit || in_word.last_byte);

  always_comb begin
    res_word.found        = hit;
    res_word.too_long     = ovf_nxt;
    if (!hit)                                      res_word.match_offset = '0;
    else if (ovf_nxt || (off > OW'(OFFSET_SAT)))   res_word.match_offset = OFFSET_SAT;
    else                                           res_word.match_offset = off[15:0];
  end

  // Window holds no reset: entries are read only after this haystack wrote them
  always_ff @(posedge clk) begin
    if (step) begin
      for (int k = 0; k < W - 1; k++) win_r[k] <= win_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      rep_r <= 1'b0;
    end else if (step) begin
      if (in_word.last_byte) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
        rep_r <= 1'b0;
      end else begin
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
        rep_r <= rep_r | hit;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/masked_byte_pattern_search_unit.sv
// Top level of the masked byte pattern search unit: word staging, result register, checks.
// A word accepted into the input stage loads its result (if any) into the output register
//   when it advances out of that stage; the output register holds the result until taken.
// Throughput: one byte per cycle unless in_stall holds it; input stage and output register
//   form a two-deep pipeline, so one word is taken while a result waits on out_stall.
// Per byte the window shift, the min(PATTERN_MAX, 32) masked byte compares and the offset
//   subtract sit between the input stage register and the output register.
// Reset (rst_n low, synchronous): pipeline empty, scan counters cleared, pattern regs zero,
//   care mask all ones, pattern length one; the byte window is not reset. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module masked_byte_pattern_search_unit #(
  parameter int unsigned     PATTERN_MAX  = mbps_pkg::PATTERN_MAX_DEF,
  parameter longint unsigned HAYSTACK_MAX = mbps_pkg::HAYSTACK_MAX_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // byte input
  input  wire                               in_valid,
  output logic                              in_stall,
  input  mbps_pkg::in_word_t                in_data,
  // result output
  output logic                              out_valid,
  input  wire                               out_stall,
  output mbps_pkg::out_word_t               out_data,
  // register writes
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [mbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [mbps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mbps_pkg::*;

  cfg_t      cfg;
  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_word_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;
  logic      accept, advance;
  logic      res_valid;
  out_word_t res_word;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  mbps_cfg_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Staged word moves on whenever the output register is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  mbps_scan #(
    .PATTERN_MAX  (PATTERN_MAX),
    .HAYSTACK_MAX (HAYSTACK_MAX)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .in_word   (s1_word_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (advance) s1_valid_nxt = 1'b0;
    if (accept)  s1_valid_nxt = 1'b1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (advance)                   out_valid_nxt = res_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept)               s1_word_r  <= in_data;
    if (advance && res_valid) out_word_r <= res_word;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // ---- checks ----

  // a taken word always lands in the input stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted word lost before input stage");

  // a staged word that cannot move keeps its contents
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_word_r)))
    else $error("staged word changed while blocked");

  // not-found reports carry a zero offset
  a_miss_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data.found) |-> (out_data.match_offset == 16'd0))
    else $error("not-found word with nonzero offset");

  // a match past the haystack limit reports a saturated offset
  a_long_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data.found && out_data.too_long) |->
      (out_data.match_offset == OFFSET_SAT))
    else $error("too-long match without saturated offset");

endmodule
`default_nettype wire
